FILE: rtl/core/rss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record selection sorter package
// Shared widths and the sequencer state type.
// ----------------------------------------------------------------------------
package rss_pkg;

   localparam int SLOT_W = 6;
   localparam int KEY_W  = 32;

   typedef enum logic [7:0] {
      ST_LOAD     = 8'b0000_0001,
      ST_CHECK    = 8'b0000_0010,
      ST_SCAN     = 8'b0000_0100,
      ST_SWAP_A   = 8'b0000_1000,
      ST_SWAP_B   = 8'b0001_0000,
      ST_EMIT_RD  = 8'b0010_0000,
      ST_EMIT_CAP = 8'b0100_0000,
      ST_EMIT_OUT = 8'b1000_0000
   } state_type;

endpackage

FILE: rtl/core/rss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
   parameter int  WIDTH = 65,
   parameter int  DEPTH = 32,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/record_selection_sorter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record selection sorter unit
// Loads a table of records, sorts the occupied slots in place by signed key
// with a swap-based selection sort, then emits every slot in order.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | carries
//   ---------+-----------+----------------------+-------------------------------
//   req_*    | in        | req_valid/req_ready  | occupied, key, payload, last
//   rsp_*    | out       | rsp_valid/rsp_ready  | slot, occupancy, key, payload,
//            |           |                      | final_res
//
// Loading takes one record per cycle. The sort walks the table through the
// single read port of the record RAM: pass i scans slots i to n-1 for the
// least occupied key and, if slot i is occupied, swaps that record into it.
// Emission reads, captures and presents each slot in turn.
// Reset (synchronous, active high) returns the unit to loading an empty table.
// req_ready is high only while loading; rsp_valid holds a transaction until
// rsp_ready takes it, and the next slot is read only after that.
// ----------------------------------------------------------------------------
module record_selection_sorter_unit #(
   parameter int DEPTH         = 32,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_occupied,
   input  logic [rss_pkg::KEY_W-1:0] req_key,
   input  logic [PAYLOAD_WIDTH-1:0]  req_payload,
   input  logic                      req_last,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [rss_pkg::SLOT_W-1:0] rsp_slot,
   output logic                      rsp_slot_occupied,
   output logic [rss_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic [PAYLOAD_WIDTH-1:0]  rsp_sorted_payload,
   output logic                      rsp_final_res
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int KEY_W  = rss_pkg::KEY_W;
   localparam int WORD_W = 1 + KEY_W + PAYLOAD_WIDTH;

   // RAM word layout: {occupied, key, payload}
   localparam int OCC_BIT = WORD_W - 1;
   localparam int KEY_MSB = WORD_W - 2;

   rss_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  load_count_ff, load_count_in;  // table size once loaded
   logic [IDX_W-1:0]  i_ff, i_in;                    // slot being filled
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;          // scan / emit pointer
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [WORD_W-1:0] best_word_ff, best_word_in;
   logic [WORD_W-1:0] head_word_ff, head_word_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [rss_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                     rsp_occ_ff, rsp_occ_in;
   logic [KEY_W-1:0]         rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_payload_ff, rsp_payload_in;
   logic                     rsp_final_ff, rsp_final_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic             req_fire;
   logic             scan_issue;
   logic             rd_occ;
   logic [KEY_W-1:0] rd_key;
   logic [KEY_W-1:0] best_key;
   logic             key_less;

   rss_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready  = (state_ff == rss_pkg::ST_LOAD);
   assign req_fire   = req_valid && req_ready;
   assign scan_issue = (rd_ptr_ff < load_count_ff);

   // shared compare: record just read against the running minimum
   assign rd_occ   = ram_rd_data[OCC_BIT];
   assign rd_key   = ram_rd_data[KEY_MSB -: KEY_W];
   assign best_key = best_word_ff[KEY_MSB -: KEY_W];
   assign key_less = ($signed(rd_key) < $signed(best_key));

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      i_in          = i_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      head_word_in  = head_word_ff;

      rsp_valid_in   = rsp_valid_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_final_in   = rsp_final_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = i_ff;
      ram_wr_data = best_word_ff;
      ram_rd_addr = rd_ptr_ff[IDX_W-1:0];

      case (state_ff)
         rss_pkg::ST_LOAD: begin
            if (req_fire) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = load_count_ff[IDX_W-1:0];
               ram_wr_data   = {req_occupied, req_key, req_payload};
               load_count_in = load_count_ff + CNT_W'(1);
               // a full table ends the load even without last
               if (req_last || load_count_ff == CNT_W'(DEPTH - 1)) begin
                  i_in     = '0;
                  state_in = rss_pkg::ST_CHECK;
               end
            end
         end

         rss_pkg::ST_CHECK: begin
            // the final slot needs no pass of its own
            if (CNT_W'(i_ff) + CNT_W'(1) < load_count_ff) begin
               rd_ptr_in     = CNT_W'(i_ff);
               best_valid_in = 1'b0;
               state_in      = rss_pkg::ST_SCAN;
            end else begin
               rd_ptr_in = '0;
               state_in  = rss_pkg::ST_EMIT_RD;
            end
         end

         rss_pkg::ST_SCAN: begin
            // read pointer runs one slot ahead of the compare
            cmp_valid_in = scan_issue;
            cmp_idx_in   = rd_ptr_ff[IDX_W-1:0];
            if (scan_issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (cmp_valid_ff) begin
               if (cmp_idx_ff == i_ff) begin
                  head_word_in = ram_rd_data;
               end
               // strict less keeps the earliest of equal keys
               if (rd_occ && (!best_valid_ff || key_less)) begin
                  best_valid_in = 1'b1;
                  best_idx_in   = cmp_idx_ff;
                  best_word_in  = ram_rd_data;
               end
            end
            if (!scan_issue && !cmp_valid_ff) begin
               // empty slots keep their place
               if (head_word_ff[OCC_BIT]) begin
                  state_in = rss_pkg::ST_SWAP_A;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = rss_pkg::ST_CHECK;
               end
            end
         end

         rss_pkg::ST_SWAP_A: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = best_word_ff;
            state_in    = rss_pkg::ST_SWAP_B;
         end

         rss_pkg::ST_SWAP_B: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = best_idx_ff;
            ram_wr_data = head_word_ff;
            i_in        = i_ff + IDX_W'(1);
            state_in    = rss_pkg::ST_CHECK;
         end

         rss_pkg::ST_EMIT_RD: begin
            state_in = rss_pkg::ST_EMIT_CAP;
         end

         rss_pkg::ST_EMIT_CAP: begin
            rsp_valid_in   = 1'b1;
            rsp_slot_in    = rss_pkg::SLOT_W'(rd_ptr_ff);
            rsp_occ_in     = rd_occ;
            rsp_key_in     = rd_occ ? rd_key : '0;
            rsp_payload_in = rd_occ ? ram_rd_data[PAYLOAD_WIDTH-1:0] : '0;
            rsp_final_in   = (rd_ptr_ff + CNT_W'(1) == load_count_ff);
            state_in       = rss_pkg::ST_EMIT_OUT;
         end

         rss_pkg::ST_EMIT_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  load_count_in = '0;
                  state_in      = rss_pkg::ST_LOAD;
               end else begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
                  state_in  = rss_pkg::ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = rss_pkg::ST_LOAD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rss_pkg::ST_LOAD;
         load_count_ff <= '0;
         i_ff          <= '0;
         rd_ptr_ff     <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         i_ff          <= i_in;
         rd_ptr_ff     <= rd_ptr_in;
         cmp_valid_ff  <= cmp_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      best_idx_ff    <= best_idx_in;
      best_word_ff   <= best_word_in;
      head_word_ff   <= head_word_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_final_ff   <= rsp_final_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_slot_occupied  = rsp_occ_ff;
   assign rsp_sorted_key     = rsp_key_ff;
   assign rsp_sorted_payload = rsp_payload_ff;
   assign rsp_final_res      = rsp_final_ff;

endmodule

FILE: rtl/core/rss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record selection sorter checker
// Port-level assertions, bound to the sorter top level.
// ----------------------------------------------------------------------------
module rss_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rss_pkg::SLOT_W-1:0] rsp_slot,
   input logic [rss_pkg::KEY_W-1:0]  rsp_sorted_key,
   input logic                       rsp_final_res
);

   // loading and emitting never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // a stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_slot) && $stable(rsp_sorted_key)
         && $stable(rsp_final_res))
      else $error("stalled response changed");

   // after the final slot the unit loads again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_res |=> req_ready)
      else $error("not ready for a new table after the final slot");

   // slots come out in order, one apart
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_res |=> ##2
         rsp_valid
         && rsp_slot == rss_pkg::SLOT_W'($past(rsp_slot, 3) + 1'b1))
      else $error("response slot out of order");

endmodule

bind record_selection_sorter_unit rss_checker u_rss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_slot       (rsp_slot),
   .rsp_sorted_key (rsp_sorted_key),
   .rsp_final_res  (rsp_final_res)
);
